[rtl/i64p_pkg.sv]
// Package for the 64-bit text-to-integer parser: parse state types, codes,
// character constants and the digit decoder. Depends on nothing.
package i64p_pkg;

	localparam int unsigned PaddrWidth = 3;
	localparam int unsigned PdataWidth = 32;
	localparam int unsigned ValueWidth = 64;
	localparam int unsigned WideWidth  = ValueWidth + 4;

	// Byte address of the mode register.
	localparam logic [PaddrWidth-1:0] REG_SIGNED_MODE_ADDR = 3'd0;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_LO_B  = 8'h62;
	localparam logic [7:0] CH_UP_B  = 8'h42;
	localparam logic [7:0] CH_LO_O  = 8'h6F;
	localparam logic [7:0] CH_UP_O  = 8'h4F;

	// Digit value 16 marks a byte that is no digit at all.
	localparam logic [4:0] DIGIT_NONE = 5'd16;

	typedef enum logic [4:0] {
		PH_START  = 5'b00001,
		PH_SIGN   = 5'b00010,
		PH_ZERO   = 5'b00100,
		PH_PREFIX = 5'b01000,
		PH_DIGITS = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		RX_DEC = 2'd0,
		RX_HEX = 2'd1,
		RX_BIN = 2'd2,
		RX_OCT = 2'd3
	} radix_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_BADDIGIT = 3'd2,
		ST_OVERFLOW = 3'd3,
		ST_MINUS    = 3'd4
	} status_t;

	typedef struct packed {
		phase_t                phase;
		logic                  is_negative;
		radix_t                radix;
		logic [ValueWidth-1:0] acc;
		status_t               sticky;
	} parse_state_t;

	typedef struct packed {
		logic                  ok;
		status_t               status;
		logic [ValueWidth-1:0] value;
	} result_t;

	localparam parse_state_t PARSE_IDLE = '{
		phase:       PH_START,
		is_negative: 1'b0,
		radix:       RX_DEC,
		acc:         '0,
		sticky:      ST_OK
	};

	function automatic logic [4:0] digit_of(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = {3'b000, DIGIT_NONE};
			if (c >= CH_ZERO && c <= CH_NINE) begin
				d = c - CH_ZERO;
			end else if (c >= CH_LO_A && c <= CH_LO_F) begin
				d = c - CH_LO_A + 8'd10;
			end else if (c >= CH_UP_A && c <= CH_UP_F) begin
				d = c - CH_UP_A + 8'd10;
			end
			digit_of = d[4:0];
		end
	endfunction

	function automatic logic [4:0] base_of(input radix_t rx);
		logic [4:0] b;
		begin
			unique case (rx)
				RX_DEC: b = 5'd10;
				RX_HEX: b = 5'd16;
				RX_BIN: b = 5'd2;
				RX_OCT: b = 5'd8;
				default: b = 5'd10;
			endcase
			base_of = b;
		end
	endfunction

endpackage

[rtl/i64p_step.sv]
// One parse step: next parse state and the result word for one text byte.
// Depends on i64p_pkg.
module i64p_step (
	input  i64p_pkg::parse_state_t cur,
	input  logic [7:0]             char_code,
	input  logic                   signed_mode,
	output i64p_pkg::parse_state_t nxt,
	output logic                   term,
	output i64p_pkg::result_t      res
);
	import i64p_pkg::*;

	radix_t                eff_rx;
	logic   [4:0]          digit;
	logic                  in_range;
	logic   [WideWidth-1:0] acc_w;
	logic   [WideWidth-1:0] scaled;
	logic   [WideWidth-1:0] sum;
	logic   [WideWidth-1:0] limit;
	logic                  over;
	logic                  do_digit;
	status_t               st;
	logic   [ValueWidth-1:0] v;

	assign term = (char_code == CH_NUL);

	// A leading zero that is not a prefix makes the number octal.
	assign eff_rx   = (cur.phase == PH_ZERO) ? RX_OCT : cur.radix;
	assign digit    = digit_of(char_code);
	assign in_range = (digit < base_of(eff_rx));

	// Scale by the base with shifts (and one add for decimal), then add the digit.
	assign acc_w = {4'b0, cur.acc};
	always_comb begin
		unique case (eff_rx)
			RX_DEC: scaled = (acc_w << 3) + (acc_w << 1);
			RX_HEX: scaled = acc_w << 4;
			RX_BIN: scaled = acc_w << 1;
			RX_OCT: scaled = acc_w << 3;
			default: scaled = acc_w;
		endcase
	end
	assign sum = scaled + {{(WideWidth-4){1'b0}}, digit[3:0]};

	always_comb begin
		if (cur.is_negative) begin
			limit = {{(WideWidth-1){1'b0}}, 1'b1} << (ValueWidth - 1);
		end else if (signed_mode) begin
			limit = ({{(WideWidth-1){1'b0}}, 1'b1} << (ValueWidth - 1))
				- {{(WideWidth-1){1'b0}}, 1'b1};
		end else begin
			limit = {4'b0, {ValueWidth{1'b1}}};
		end
	end
	assign over = (sum > limit);

	// Next state.
	always_comb begin
		nxt      = cur;
		do_digit = 1'b0;
		if (term) begin
			nxt = PARSE_IDLE;
		end else if (cur.sticky == ST_OK) begin
			unique case (cur.phase)
				PH_SIGN: begin
					if (char_code == CH_ZERO) begin
						nxt.phase = PH_ZERO;
					end else begin
						do_digit = 1'b1;
					end
				end
				PH_ZERO: begin
					priority if (char_code == CH_LO_X || char_code == CH_UP_X) begin
						nxt.radix = RX_HEX;
						nxt.phase = PH_PREFIX;
					end else if (char_code == CH_LO_B || char_code == CH_UP_B) begin
						nxt.radix = RX_BIN;
						nxt.phase = PH_PREFIX;
					end else if (char_code == CH_LO_O || char_code == CH_UP_O) begin
						nxt.radix = RX_OCT;
						nxt.phase = PH_PREFIX;
					end else begin
						do_digit = 1'b1;
					end
				end
				PH_PREFIX, PH_DIGITS: begin
					do_digit = 1'b1;
				end
				default: begin
					priority if (char_code == CH_MINUS) begin
						if (signed_mode) begin
							nxt.is_negative = 1'b1;
							nxt.phase       = PH_SIGN;
						end else begin
							nxt.sticky = ST_MINUS;
						end
					end else if (char_code == CH_PLUS) begin
						nxt.phase = PH_SIGN;
					end else if (char_code == CH_ZERO) begin
						nxt.phase = PH_ZERO;
					end else begin
						do_digit = 1'b1;
					end
				end
			endcase
			if (do_digit) begin
				nxt.phase = PH_DIGITS;
				nxt.radix = eff_rx;
				priority if (!in_range) begin
					nxt.sticky = ST_BADDIGIT;
				end else if (over) begin
					nxt.sticky = ST_OVERFLOW;
				end else begin
					nxt.acc = sum[ValueWidth-1:0];
				end
			end
		end
	end

	// Result word on the terminator.
	always_comb begin
		st = cur.sticky;
		v  = '0;
		if (cur.sticky == ST_OK) begin
			priority if (cur.phase == PH_ZERO) begin
				v = '0;
			end else if (cur.phase == PH_DIGITS) begin
				v = cur.is_negative ? (~cur.acc + {{(ValueWidth-1){1'b0}}, 1'b1})
					: cur.acc;
			end else begin
				st = ST_EMPTY;
			end
		end
		res.ok     = (st == ST_OK);
		res.status = st;
		res.value  = (st == ST_OK) ? v : '0;
	end

endmodule

[rtl/int64_text_to_integer_parser.sv]
// Top level of the 64-bit text-to-integer parser: input byte register,
// parse state, result register and the mode register port. Depends on
// i64p_pkg and i64p_step.
//
//   channel   | handshake                    | word
//   ----------+------------------------------+--------------------------
//   char      | char_valid / char_stall      | char_code[7:0]
//   result    | result_valid / result_stall  | ok, status[2:0], value[63:0]
//   config    | APB psel/penable/pwrite      | signed_mode at byte 0
//
// One byte enters per cycle while char_stall is low. A byte is held in
// the input register, then one parse step (shift-add of the accumulator
// and the range compare) updates the parse state; a terminator loads the
// result register, which holds the result until it is taken.
// The only stall source is a terminator that finds the result register
// still full and stalled; other bytes keep flowing past a waiting result.
// Reset clears the parse state and sets signed mode.
module int64_text_to_integer_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	// byte channel
	input  logic                              char_valid,
	output logic                              char_stall,
	input  logic [7:0]                        char_code,
	// result channel
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic                              ok,
	output logic [2:0]                        status,
	output logic [i64p_pkg::ValueWidth-1:0]   value,
	// configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [i64p_pkg::PaddrWidth-1:0]   paddr,
	input  logic [i64p_pkg::PdataWidth-1:0]   pwdata,
	output logic [i64p_pkg::PdataWidth-1:0]   prdata,
	output logic                              pready
);
	import i64p_pkg::*;

	logic         signed_mode_q;
	logic         valid_s1;
	logic [7:0]   char_s1;
	parse_state_t state_q;
	parse_state_t state_nxt;
	logic         term_s1;
	result_t      res_nxt;
	result_t      res_q;
	logic         result_valid_q;
	logic         advance;

	// Mode register: written in the APB access phase, always ready.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q <= 1'b1;
		end else if (psel && penable && pwrite && paddr == REG_SIGNED_MODE_ADDR) begin
			signed_mode_q <= pwdata[0];
		end
	end
	assign prdata = (paddr == REG_SIGNED_MODE_ADDR)
		? {{(PdataWidth-1){1'b0}}, signed_mode_q} : '0;

	// Advance the held byte unless it is a terminator blocked by a full,
	// stalled result register.
	assign advance    = valid_s1 && (!term_s1 || !result_valid_q || !result_stall);
	assign char_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			char_s1 <= char_code;
		end
	end

	i64p_step u_step (
		.cur         (state_q),
		.char_code   (char_s1),
		.signed_mode (signed_mode_q),
		.nxt         (state_nxt),
		.term        (term_s1),
		.res         (res_nxt)
	);

	// Parse state: one update per advanced byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PARSE_IDLE;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register: load on a terminator, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && term_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && term_s1) begin
			res_q <= res_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign ok           = res_q.ok;
	assign status       = res_q.status;
	assign value        = res_q.value;

endmodule
